// ===== sv/track_distance_decimator_assert.svh =====
// Assertion macros used by the checker file of the track decimator.
`ifndef TRACK_DISTANCE_DECIMATOR_ASSERT_SVH
`define TRACK_DISTANCE_DECIMATOR_ASSERT_SVH

// Checks that a property holds at every rising clock edge outside reset.
`define TDD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Checks that a condition leads to a consequence in the next cycle.
`define TDD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/tdd_pkg.sv =====
`timescale 1ns / 1ps

package tdd_pkg;

    // Coordinates are signed two's complement with four fractional bits.
    localparam int COORD_WIDTH = 16;
    localparam int TAG_WIDTH   = 32;

    // Minimum distance register and the width of the squared distance.
    localparam int DIST_WIDTH   = 12;
    localparam int SQ_WIDTH     = 2 * DIST_WIDTH + 1;
    localparam int MIN_SQ_WIDTH = 2 * DIST_WIDTH;

    localparam logic [DIST_WIDTH-1:0]   MIN_DIST_RESET = DIST_WIDTH'(32);
    localparam logic [MIN_SQ_WIDTH-1:0] MIN_SQ_RESET   = MIN_SQ_WIDTH'(32 * 32);

    // One input point.
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] screen_x;
        logic signed [COORD_WIDTH-1:0] screen_y;
        logic        [TAG_WIDTH-1:0]   point_tag;
        logic                          first_point;
        logic                          last_point;
    } point_t;

    // One kept point.
    typedef struct packed {
        logic        [TAG_WIDTH-1:0]   kept_tag;
        logic signed [COORD_WIDTH-1:0] kept_x;
        logic signed [COORD_WIDTH-1:0] kept_y;
        logic                          forced_keep;
    } kept_t;

    // Handshake between the decision stage and the output register.
    typedef struct packed {
        logic load;
        logic free;
    } out_ctrl_t;

endpackage

// ===== sv/tdd_dist_check.sv =====
`timescale 1ns / 1ps

module tdd_dist_check import tdd_pkg::*; (
    input  logic signed [COORD_WIDTH-1:0]  point_x,
    input  logic signed [COORD_WIDTH-1:0]  point_y,
    input  logic signed [COORD_WIDTH-1:0]  anchor_x,
    input  logic signed [COORD_WIDTH-1:0]  anchor_y,
    input  logic        [MIN_SQ_WIDTH-1:0] min_sq,
    output logic                           far
);

    logic signed [COORD_WIDTH:0] dx;
    logic signed [COORD_WIDTH:0] dy;
    logic        [COORD_WIDTH:0] abs_dx;
    logic        [COORD_WIDTH:0] abs_dy;
    logic                        big;
    logic        [SQ_WIDTH-1:0]  sq;

    // Offsets from the anchor, one bit wider so they cannot overflow.
    always_comb
    begin
        dx = {point_x[COORD_WIDTH-1], point_x} - {anchor_x[COORD_WIDTH-1], anchor_x};
        dy = {point_y[COORD_WIDTH-1], point_y} - {anchor_y[COORD_WIDTH-1], anchor_y};
        abs_dx = dx[COORD_WIDTH] ? unsigned'(-dx) : unsigned'(dx);
        abs_dy = dy[COORD_WIDTH] ? unsigned'(-dy) : unsigned'(dy);
    end

    // An offset beyond the register range is always far enough, so only the
    // low bits of each offset are squared.
    always_comb
    begin
        big = (|abs_dx[COORD_WIDTH:DIST_WIDTH]) || (|abs_dy[COORD_WIDTH:DIST_WIDTH]);
        sq  = SQ_WIDTH'(abs_dx[DIST_WIDTH-1:0] * abs_dx[DIST_WIDTH-1:0])
            + SQ_WIDTH'(abs_dy[DIST_WIDTH-1:0] * abs_dy[DIST_WIDTH-1:0]);
        far = big || (sq >= SQ_WIDTH'(min_sq));
    end

endmodule

// ===== sv/tdd_out_reg.sv =====
`timescale 1ns / 1ps

module tdd_out_reg import tdd_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  kept_t     load_data,
    output out_ctrl_t ctrl,
    output logic      kept_valid,
    input  logic      kept_stall,
    output kept_t     kept
);

    logic  valid_reg;
    logic  valid_next;
    logic  free;
    kept_t data_reg;

    // The register can take a new beat when empty or when it is being drained.
    always_comb
    begin
        free       = !valid_reg || !kept_stall;
        valid_next = free ? load : valid_reg;
        ctrl.load  = load;
        ctrl.free  = free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload holds while stalled.
    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            data_reg <= load_data;
        end
    end

    assign kept_valid = valid_reg;
    assign kept       = data_reg;

endmodule

// ===== sv/track_distance_decimator.sv =====
`timescale 1ns / 1ps

// Channel     Direction  Handshake                 Payload
// point       in         point_valid / point_stall point_t
// kept        out        kept_valid / kept_stall   kept_t
// min_dist    in         min_distance_we           12 bit minimum spacing
//
// One point can be accepted in every cycle while point_stall is low. A kept
// point passes through the input register and then the output register. The
// distance test runs combinationally from the input register to the anchor
// register, so the next point sees the updated anchor. Reset clears the
// anchor to zero and sets the minimum distance to 32. Only a point to be kept
// waits in the input register behind a full, stalled output.

module track_distance_decimator import tdd_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  point_valid,
    output logic                  point_stall,
    input  point_t                point,
    output logic                  kept_valid,
    input  logic                  kept_stall,
    output kept_t                 kept,
    input  logic                  min_distance_we,
    input  logic [DIST_WIDTH-1:0] min_distance_wdata
);

    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    point_t                        s1_point_reg;
    logic signed [COORD_WIDTH-1:0] anchor_x_reg;
    logic signed [COORD_WIDTH-1:0] anchor_y_reg;
    logic        [MIN_SQ_WIDTH-1:0] min_sq_reg;
    logic                          far;
    logic                          forced;
    logic                          emit;
    logic                          accept;
    logic                          advance;
    kept_t                         kept_data;
    out_ctrl_t                     out_ctrl;

    // The squared threshold is kept instead of the register value itself.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sq_reg <= MIN_SQ_RESET;
        end
        else if (min_distance_we)
        begin
            min_sq_reg <= MIN_SQ_WIDTH'(min_distance_wdata * min_distance_wdata);
        end
    end

    tdd_dist_check u_dist (
        .point_x  (s1_point_reg.screen_x),
        .point_y  (s1_point_reg.screen_y),
        .anchor_x (anchor_x_reg),
        .anchor_y (anchor_y_reg),
        .min_sq   (min_sq_reg),
        .far      (far)
    );

    // Keep decision and input handshake.
    always_comb
    begin
        forced        = s1_point_reg.first_point || s1_point_reg.last_point;
        emit          = s1_valid_reg && (forced || far);
        point_stall   = emit && !out_ctrl.free;
        advance       = !point_stall;
        accept        = point_valid && !point_stall;
        s1_valid_next = advance ? point_valid : s1_valid_reg;

        kept_data.kept_tag    = s1_point_reg.point_tag;
        kept_data.kept_x      = s1_point_reg.screen_x;
        kept_data.kept_y      = s1_point_reg.screen_y;
        kept_data.forced_keep = forced;
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_point_reg <= point;
        end
    end

    // Every kept point becomes the new anchor.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            anchor_x_reg <= '0;
            anchor_y_reg <= '0;
        end
        else if (out_ctrl.load && out_ctrl.free)
        begin
            anchor_x_reg <= s1_point_reg.screen_x;
            anchor_y_reg <= s1_point_reg.screen_y;
        end
    end

    tdd_out_reg u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (emit),
        .load_data  (kept_data),
        .ctrl       (out_ctrl),
        .kept_valid (kept_valid),
        .kept_stall (kept_stall),
        .kept       (kept)
    );

endmodule

// ===== sv/tdd_checker.sv =====
`timescale 1ns / 1ps
`include "track_distance_decimator_assert.svh"

module tdd_checker import tdd_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  point_valid,
    input logic                  point_stall,
    input point_t                point,
    input logic                  kept_valid,
    input logic                  kept_stall,
    input kept_t                 kept,
    input logic                  min_distance_we,
    input logic [DIST_WIDTH-1:0] min_distance_wdata
);

    // A stalled output beat stays and holds its payload.
    `TDD_ASSERT_NEXT(a_kept_hold, clk, rst_n, kept_valid && kept_stall, kept_valid && $stable(kept))

    // The input only stalls behind a full, stalled output register.
    `TDD_ASSERT(a_stall_cause, clk, rst_n, !point_stall || (kept_valid && kept_stall))

    // A first or last point always comes out of the output register, marked as
    // forced, when the output can take it from the input register.
    `TDD_ASSERT(a_forced_out, clk, rst_n,
        (point_valid && !point_stall && (point.first_point || point.last_point))
        ##1 (!kept_valid || !kept_stall)
        |=> (kept_valid && kept.forced_keep && kept.kept_tag == $past(point.point_tag, 2)))

    // The configuration data is never unknown while the write enable is high.
    `TDD_ASSERT(a_cfg_known, clk, rst_n,
        !min_distance_we || !$isunknown(min_distance_wdata))

endmodule

bind track_distance_decimator tdd_checker u_tdd_checker (.*);

// ===== verif/track_distance_decimator_tb.sv =====
`timescale 1ns / 1ps

module track_distance_decimator_tb;

    import tdd_pkg::*;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam int IDLE_PERCENT   = 24;
    localparam int STALL_LIMIT    = 1000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int PHASE_POINTS   = 255;

    // Predicts which points survive the spacing test and holds the kept points
    // that have not yet come out of the block.
    class kept_point_predictor;
        coord_t                anchor_x;
        coord_t                anchor_y;
        logic [DIST_WIDTH-1:0] min_dist;
        kept_t                 expected_kept[$];
        int                    errors;

        function new();
            anchor_x = '0;
            anchor_y = '0;
            min_dist = MIN_DIST_RESET;
            errors   = 0;
        endfunction

        function void set_min_distance(logic [DIST_WIDTH-1:0] value);
            min_dist = value;
        endfunction

        // A point far enough from the anchor passes; any offset of 4096 or more
        // on one axis passes outright.
        function bit clears_spacing(coord_t x, coord_t y);
            longint dx;
            longint dy;
            longint sq;
            longint lim;
            dx = longint'(x) - longint'(anchor_x);
            dy = longint'(y) - longint'(anchor_y);
            if (dx < 0)
                dx = -dx;
            if (dy < 0)
                dy = -dy;
            if (dx >= 4096 || dy >= 4096)
                return 1'b1;
            sq  = dx * dx + dy * dy;
            lim = longint'(min_dist) * longint'(min_dist);
            return sq >= lim;
        endfunction

        // Called for every accepted input beat.
        function void note_point(point_t p);
            kept_t k;
            bit    forced;
            forced = p.first_point || p.last_point;
            if (!forced && !clears_spacing(p.screen_x, p.screen_y))
                return;
            anchor_x      = p.screen_x;
            anchor_y      = p.screen_y;
            k.kept_tag    = p.point_tag;
            k.kept_x      = p.screen_x;
            k.kept_y      = p.screen_y;
            k.forced_keep = forced;
            expected_kept = {expected_kept, k};
        endfunction

        // Called for every accepted output beat.
        function void check_kept(kept_t k);
            kept_t want;
            if (expected_kept.size() == 0)
            begin
                $error("kept beat with no point pending: kept_tag %h", k.kept_tag);
                errors++;
                return;
            end
            want = expected_kept.pop_front();
            if (k.kept_tag !== want.kept_tag)
            begin
                $error("kept_tag: expected %h, actual %h", want.kept_tag, k.kept_tag);
                errors++;
            end
            if (k.kept_x !== want.kept_x)
            begin
                $error("kept_x: expected %0d, actual %0d", want.kept_x, k.kept_x);
                errors++;
            end
            if (k.kept_y !== want.kept_y)
            begin
                $error("kept_y: expected %0d, actual %0d", want.kept_y, k.kept_y);
                errors++;
            end
            if (k.forced_keep !== want.forced_keep)
            begin
                $error("forced_keep: expected %0d, actual %0d",
                       want.forced_keep, k.forced_keep);
                errors++;
            end
        endfunction

        function int pending();
            return expected_kept.size();
        endfunction

        // Anything still waiting at the end never came out of the block.
        function void close_out();
            if (expected_kept.size() != 0)
            begin
                $error("%0d kept points never arrived, first kept_tag %h",
                       expected_kept.size(), expected_kept[0].kept_tag);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  point_valid;
    logic                  point_stall;
    point_t                point;
    logic                  kept_valid;
    logic                  kept_stall;
    kept_t                 kept;
    logic                  min_distance_we;
    logic [DIST_WIDTH-1:0] min_distance_wdata;

    kept_point_predictor   board = new();
    bit                    steady;
    int                    quiet_cycles = 0;

    track_distance_decimator u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .point_valid        (point_valid),
        .point_stall        (point_stall),
        .point              (point),
        .kept_valid         (kept_valid),
        .kept_stall         (kept_stall),
        .kept               (kept),
        .min_distance_we    (min_distance_we),
        .min_distance_wdata (min_distance_wdata)
    );

    // Clock source.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver side: random stall, none during a steady stretch.
    always @(negedge clk)
    begin
        kept_stall <= !steady && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Beat monitor and watchdog on cycles where nothing moves.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point_valid && !point_stall)
                board.note_point(point);
            if (kept_valid && !kept_stall)
                board.check_kept(kept);
            if ((point_valid && !point_stall) || (kept_valid && !kept_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[track_distance_decimator] ERROR");
                $finish;
            end
        end
    end

    function automatic point_t track_point(int x, int y, logic [TAG_WIDTH-1:0] tag,
                                           bit first, bit last);
        point_t p;
        p.screen_x    = coord_t'(x);
        p.screen_y    = coord_t'(y);
        p.point_tag   = tag;
        p.first_point = first;
        p.last_point  = last;
        return p;
    endfunction

    // Presents one beat, with a random gap in front, and returns at the falling
    // edge after it was taken. Valid stays high for a following beat.
    task automatic send_point(input point_t p);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            point_valid <= 1'b0;
            @(negedge clk);
        end
        point_valid <= 1'b1;
        point       <= p;
        do
            @(posedge clk);
        while (point_stall);
        @(negedge clk);
    endtask

    // Stops the input and waits until the block has emptied out.
    task automatic settle();
        point_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_min_distance(input logic [DIST_WIDTH-1:0] value);
        min_distance_we    <= 1'b1;
        min_distance_wdata <= value;
        @(negedge clk);
        min_distance_we    <= 1'b0;
        board.set_min_distance(value);
    endtask

    // Mostly complete tracks that wander around the spacing limit, mixed with
    // broken tracks and full-range noise points.
    task automatic run_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        int unsigned kind;
        int          reach;
        int          step_x;
        int          step_y;
        coord_t      px;
        coord_t      py;
        point_t      p;
        sent  = 0;
        reach = int'(board.min_dist) + int'(board.min_dist) / 2 + 3;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 9);
            if (kind < 8)
            begin
                len = $urandom_range(2, 14);
                px  = coord_t'($urandom);
                py  = coord_t'($urandom);
                for (int i = 0; i < len; i++)
                begin
                    p.screen_x    = px;
                    p.screen_y    = py;
                    p.point_tag   = $urandom;
                    // Kind 7 drops the first mark, kind 6 the last mark, and
                    // kind 5 may restart the track midway.
                    p.first_point = (i == 0 && kind != 7) ||
                                    (kind == 5 && $urandom_range(0, 3) == 0);
                    p.last_point  = (i == len - 1 && kind != 6);
                    send_point(p);
                    sent++;
                    step_x = int'($urandom_range(0, 2 * reach)) - reach;
                    step_y = int'($urandom_range(0, 2 * reach)) - reach;
                    px     = px + coord_t'(step_x);
                    py     = py + coord_t'(step_y);
                end
            end
            else
            begin
                p.screen_x    = coord_t'($urandom);
                p.screen_y    = coord_t'($urandom);
                p.point_tag   = $urandom;
                p.first_point = (kind == 8) ? 1'($urandom_range(0, 1)) : 1'b0;
                p.last_point  = (kind == 8) ? 1'($urandom_range(0, 1)) : 1'b0;
                send_point(p);
                sent++;
            end
        end
    endtask

    // Main sequence.
    initial
    begin
        rst_n              = 1'b0;
        point_valid        = 1'b0;
        point              = '0;
        min_distance_we    = 1'b0;
        min_distance_wdata = '0;
        steady             = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset spacing of 32: points before any first mark, the exact limit,
        // the coordinate extremes, first and last together, and a last point.
        send_point(track_point(0, 0, 32'h0000_0000, 1'b0, 1'b0));
        send_point(track_point(31, 0, 32'h0000_0001, 1'b0, 1'b0));
        send_point(track_point(32, 0, 32'h0000_0002, 1'b0, 1'b0));
        send_point(track_point(52, 24, 32'h0000_0003, 1'b0, 1'b0));
        send_point(track_point(52, 25, 32'h0000_0004, 1'b0, 1'b0));
        send_point(track_point(-32768, 32767, 32'hFFFF_FFFF, 1'b1, 1'b1));
        send_point(track_point(-32768, -32768, 32'hAAAA_AAAA, 1'b1, 1'b0));
        send_point(track_point(-32768, -32768, 32'h5555_5555, 1'b0, 1'b0));
        send_point(track_point(-28672, -32768, 32'h0000_0006, 1'b0, 1'b0));
        send_point(track_point(-28672, -32768, 32'h0000_0007, 1'b0, 1'b1));
        send_point(track_point(-28662, -32768, 32'h0000_0008, 1'b0, 1'b0));
        send_point(track_point(32767, 32767, 32'h0000_0009, 1'b0, 1'b0));
        send_point(track_point(32767, -32768, 32'h0000_000A, 1'b0, 1'b0));
        send_point(track_point(-1, -1, 32'h0000_000B, 1'b0, 1'b0));
        settle();

        // Zero spacing keeps even a repeated point.
        write_min_distance(DIST_WIDTH'(0));
        send_point(track_point(-1, -1, 32'h0000_000C, 1'b0, 1'b0));
        send_point(track_point(0, -1, 32'h0000_000D, 1'b0, 1'b0));
        settle();

        // Largest spacing: the exact limit, the diagonal edge and large offsets.
        write_min_distance(DIST_WIDTH'(4095));
        send_point(track_point(0, 0, 32'h0000_000E, 1'b1, 1'b0));
        send_point(track_point(4094, 0, 32'h0000_000F, 1'b0, 1'b0));
        send_point(track_point(4095, 0, 32'h0000_0010, 1'b0, 1'b0));
        send_point(track_point(6990, 2895, 32'h0000_0011, 1'b0, 1'b0));
        send_point(track_point(6991, 2896, 32'h0000_0012, 1'b0, 1'b0));
        send_point(track_point(11086, 6991, 32'h0000_0013, 1'b0, 1'b0));
        send_point(track_point(11086, 11087, 32'h0000_0014, 1'b0, 1'b0));
        send_point(track_point(6990, 11187, 32'h0000_0015, 1'b0, 1'b0));
        send_point(track_point(6990, 11187, 32'h0000_0016, 1'b0, 1'b1));
        settle();

        // Random tracks under several spacings; one phase runs without idling.
        write_min_distance(MIN_DIST_RESET);
        run_phase(PHASE_POINTS);
        settle();
        write_min_distance(DIST_WIDTH'(1));
        run_phase(PHASE_POINTS);
        settle();
        write_min_distance(DIST_WIDTH'($urandom_range(2, 200)));
        steady = 1'b1;
        run_phase(PHASE_POINTS);
        settle();
        steady = 1'b0;
        write_min_distance(DIST_WIDTH'(0));
        run_phase(PHASE_POINTS);
        settle();
        write_min_distance(DIST_WIDTH'(4095));
        run_phase(PHASE_POINTS);
        settle();
        write_min_distance(DIST_WIDTH'($urandom_range(200, 4094)));
        run_phase(PHASE_POINTS);
        settle();

        repeat (8) @(negedge clk);
        board.close_out();
        if (board.errors == 0)
            $display("[track_distance_decimator] OK");
        else
            $display("[track_distance_decimator] ERROR");
        $finish;
    end

endmodule
